FILE: sv/gbn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gbn_pkg;

    localparam int SEQ_W   = 3;
    localparam int PAY_W   = 32;
    localparam int SEQ_MOD = 8;

    localparam logic [SEQ_W-1:0] MAX_SEQ = 3'd7;

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 40;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [1:0] OP_SEND    = 2'd0;
    localparam logic [1:0] OP_RX      = 2'd1;
    localparam logic [1:0] OP_CRC_ERR = 2'd2;
    localparam logic [1:0] OP_TIMEOUT = 2'd3;

    typedef enum logic [1:0] {
        KIND_TX      = 2'd0,
        KIND_DELIVER = 2'd1,
        KIND_NONE    = 2'd2,
        KIND_REFUSED = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        CMD_SEND = 2'd0,
        CMD_RX   = 2'd1,
        CMD_NONE = 2'd2,
        CMD_RETX = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t        cmd;
        logic [PAY_W-1:0] payload;
        logic [SEQ_W-1:0] seq;
        logic [SEQ_W-1:0] ack;
    } cmd_t;

    typedef struct packed {
        kind_t            kind;
        logic [SEQ_W-1:0] seq;
        logic [SEQ_W-1:0] ack;
        logic [PAY_W-1:0] data;
        logic             window_open;
        logic             last;
    } result_t;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_RETX = 1'b1
    } back_state_t;

endpackage

`default_nettype wire

FILE: sv/gbn_front.sv
`timescale 1ns / 1ps
`default_nettype none

module gbn_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [gbn_pkg::IN_TDATA_W-1:0] s_tdata,
    input  wire logic [1:0]                     s_tuser,
    output logic                                q_valid,
    output gbn_pkg::cmd_t                       q_entry,
    input  wire logic                           q_pop
);

    gbn_pkg::cmd_t                    entry_reg [gbn_pkg::QUEUE_DEPTH];
    logic [gbn_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [gbn_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [gbn_pkg::QCNT_W-1:0]       count_reg, count_next;
    gbn_pkg::cmd_t                    decoded;
    logic                             push;
    logic                             pop;

    always_comb
    begin
        decoded.seq = s_tdata[gbn_pkg::PAY_W+gbn_pkg::SEQ_W-1:gbn_pkg::PAY_W];
        decoded.ack = s_tdata[gbn_pkg::PAY_W+2*gbn_pkg::SEQ_W-1:
                              gbn_pkg::PAY_W+gbn_pkg::SEQ_W];
        case (s_tuser)
            gbn_pkg::OP_SEND:
            begin
                decoded.cmd     = gbn_pkg::CMD_SEND;
                decoded.payload = s_tdata[gbn_pkg::PAY_W-1:0];
            end
            gbn_pkg::OP_RX:
            begin
                decoded.cmd     = gbn_pkg::CMD_RX;
                decoded.payload = s_tdata[2*gbn_pkg::PAY_W+2*gbn_pkg::SEQ_W-1:
                                          gbn_pkg::PAY_W+2*gbn_pkg::SEQ_W];
            end
            gbn_pkg::OP_TIMEOUT:
            begin
                decoded.cmd     = gbn_pkg::CMD_RETX;
                decoded.payload = '0;
            end
            default:
            begin
                decoded.cmd     = gbn_pkg::CMD_NONE;
                decoded.payload = '0;
            end
        endcase
    end

    assign s_tready = (count_reg != gbn_pkg::QCNT_W'(gbn_pkg::QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_entry  = entry_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

`default_nettype wire

FILE: sv/gbn_back.sv
`timescale 1ns / 1ps
`default_nettype none

module gbn_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_valid,
    input  wire gbn_pkg::cmd_t  q_entry,
    output logic                q_pop,
    output logic                res_valid,
    input  wire logic           res_ready,
    output gbn_pkg::result_t    res
);

    gbn_pkg::back_state_t              state_reg, state_next;
    logic [gbn_pkg::SEQ_W-1:0]         next_to_send_reg, next_to_send_next;
    logic [gbn_pkg::SEQ_W-1:0]         oldest_reg, oldest_next;
    logic [gbn_pkg::SEQ_W-1:0]         expected_reg, expected_next;
    logic [gbn_pkg::SEQ_W-1:0]         outstanding_reg, outstanding_next;
    logic [gbn_pkg::SEQ_W-1:0]         retx_ptr_reg, retx_ptr_next;
    logic [gbn_pkg::SEQ_W-1:0]         retx_left_reg, retx_left_next;
    logic [gbn_pkg::PAY_W-1:0]         store_reg [gbn_pkg::SEQ_MOD];
    logic                              store_we;
    logic                              out_valid_reg, out_valid_next;
    gbn_pkg::result_t                  res_reg, res_next;
    logic                              can_load;
    logic                              load;
    logic [gbn_pkg::SEQ_W-1:0]         ack_word;
    logic [gbn_pkg::SEQ_W-1:0]         ack_dist;

    assign can_load  = !out_valid_reg || res_ready;
    assign q_pop     = (state_reg == gbn_pkg::BK_IDLE) && q_valid && can_load;
    assign ack_word  = expected_reg - 1'b1;
    assign ack_dist  = q_entry.ack - oldest_reg;
    assign res_valid = out_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gbn_pkg::BK_IDLE:
            begin
                if (q_pop && q_entry.cmd == gbn_pkg::CMD_RETX && outstanding_reg > 3'd1)
                begin
                    state_next = gbn_pkg::BK_RETX;
                end
            end
            gbn_pkg::BK_RETX:
            begin
                if (can_load && retx_left_reg == 3'd1)
                begin
                    state_next = gbn_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = gbn_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        next_to_send_next = next_to_send_reg;
        oldest_next       = oldest_reg;
        expected_next     = expected_reg;
        outstanding_next  = outstanding_reg;
        retx_ptr_next     = retx_ptr_reg;
        retx_left_next    = retx_left_reg;
        res_next          = res_reg;
        store_we          = 1'b0;
        load              = 1'b0;
        case (state_reg)
            gbn_pkg::BK_IDLE:
            begin
                if (q_pop)
                begin
                    load              = 1'b1;
                    res_next.kind     = gbn_pkg::KIND_NONE;
                    res_next.seq      = '0;
                    res_next.ack      = '0;
                    res_next.data     = '0;
                    res_next.last     = 1'b1;
                    case (q_entry.cmd)
                        gbn_pkg::CMD_SEND:
                        begin
                            if (outstanding_reg != gbn_pkg::MAX_SEQ)
                            begin
                                store_we          = 1'b1;
                                res_next.kind     = gbn_pkg::KIND_TX;
                                res_next.seq      = next_to_send_reg;
                                res_next.ack      = ack_word;
                                res_next.data     = q_entry.payload;
                                outstanding_next  = outstanding_reg + 1'b1;
                                next_to_send_next = next_to_send_reg + 1'b1;
                            end
                            else
                            begin
                                res_next.kind = gbn_pkg::KIND_REFUSED;
                            end
                        end
                        gbn_pkg::CMD_RX:
                        begin
                            if (q_entry.seq == expected_reg)
                            begin
                                res_next.kind = gbn_pkg::KIND_DELIVER;
                                res_next.data = q_entry.payload;
                                expected_next = expected_reg + 1'b1;
                            end
                            if (ack_dist < outstanding_reg)
                            begin
                                oldest_next      = q_entry.ack + 1'b1;
                                outstanding_next = outstanding_reg - ack_dist - 1'b1;
                            end
                        end
                        gbn_pkg::CMD_RETX:
                        begin
                            if (outstanding_reg != '0)
                            begin
                                res_next.kind  = gbn_pkg::KIND_TX;
                                res_next.seq   = oldest_reg;
                                res_next.ack   = ack_word;
                                res_next.data  = store_reg[oldest_reg];
                                res_next.last  = (outstanding_reg == 3'd1);
                                retx_ptr_next  = oldest_reg + 1'b1;
                                retx_left_next = outstanding_reg - 1'b1;
                            end
                        end
                        default:
                        begin
                            res_next.kind = gbn_pkg::KIND_NONE;
                        end
                    endcase
                    res_next.window_open = (outstanding_next != gbn_pkg::MAX_SEQ);
                end
            end
            gbn_pkg::BK_RETX:
            begin
                if (can_load)
                begin
                    load                 = 1'b1;
                    res_next.kind        = gbn_pkg::KIND_TX;
                    res_next.seq         = retx_ptr_reg;
                    res_next.ack         = ack_word;
                    res_next.data        = store_reg[retx_ptr_reg];
                    res_next.window_open = (outstanding_reg != gbn_pkg::MAX_SEQ);
                    res_next.last        = (retx_left_reg == 3'd1);
                    retx_ptr_next        = retx_ptr_reg + 1'b1;
                    retx_left_next       = retx_left_reg - 1'b1;
                end
            end
            default:
            begin
                load = 1'b0;
            end
        endcase
        out_valid_next = load ? 1'b1 : (res_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= gbn_pkg::BK_IDLE;
            next_to_send_reg <= '0;
            oldest_reg       <= '0;
            expected_reg     <= '0;
            outstanding_reg  <= '0;
            retx_ptr_reg     <= '0;
            retx_left_reg    <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            next_to_send_reg <= next_to_send_next;
            oldest_reg       <= oldest_next;
            expected_reg     <= expected_next;
            outstanding_reg  <= outstanding_next;
            retx_ptr_reg     <= retx_ptr_next;
            retx_left_reg    <= retx_left_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (store_we)
        begin
            store_reg[next_to_send_reg] <= q_entry.payload;
        end
    end

endmodule

`default_nettype wire

FILE: sv/go_back_n_arq_endpoint.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Transfer carries
// s_*       in         one link event: send, frame arrival, checksum error or timeout
// m_*       out        one result: transmit, deliver, no action or refusal
//
// An event is loaded into the output register once it is popped from the queue.
// With no stall, a timeout gives one result per cycle per outstanding frame, up to 7.
// Other events give a single result, so with no stall one event per cycle is taken.
// Reset clears the sequence counters and the two-entry event queue at once.
// A stall on m_* fills the queue, after which s_tready falls.

module go_back_n_arq_endpoint (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // send_payload[31:0], rx_seq[34:32], rx_ack[37:35], rx_payload[69:38]
    input  wire logic [gbn_pkg::IN_TDATA_W-1:0]  s_tdata,
    // op[1:0]
    input  wire logic [1:0]                      s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // tx_seq[2:0], tx_ack[5:3], data_word[37:6], window_open[38]
    output logic [gbn_pkg::OUT_TDATA_W-1:0]      m_tdata,
    // kind[1:0]
    output logic [1:0]                           m_tuser,
    output logic                                 m_tlast
);

    logic              q_valid;
    gbn_pkg::cmd_t     q_entry;
    logic              q_pop;
    gbn_pkg::result_t  res;

    gbn_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_entry  (q_entry),
        .q_pop    (q_pop)
    );

    gbn_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .q_pop     (q_pop),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {1'b0, res.window_open, res.data, res.ack, res.seq};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

endmodule

`default_nettype wire
